FILE: rtl/bfns_pkg.sv
// Shared types, constants and the bit-count function for the bitmap search block.
package bfns_pkg;

  localparam int NUM_BITS   = 4096;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W     = $clog2(NUM_WORDS);
  localparam int BIDX_W     = $clog2(WORD_BITS);
  localparam int POS_W      = 12;
  localparam int LIMIT_W    = 13;
  localparam int KIND_W     = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  // APB register map (byte addresses)
  localparam int               PADDR_W       = 3;
  localparam logic [PADDR_W-1:0] ADDR_BITS_IN_USE = 3'd0;

  localparam logic [31:0] POP_M1 = 32'h5555_5555;
  localparam logic [31:0] POP_M2 = 32'h3333_3333;
  localparam logic [31:0] POP_M4 = 32'h0F0F_0F0F;
  localparam logic [31:0] POP_M8 = 32'h0101_0101;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET       = 3'd0,
    KIND_CLEAR     = 3'd1,
    KIND_TEST      = 3'd2,
    KIND_CLEAR_ALL = 3'd3,
    KIND_FIND      = 3'd4
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
  } cmd_word_t;

  typedef struct packed {
    logic             bit_value;
    logic             found;
    logic [POS_W-1:0] found_position;
    logic             out_of_range;
  } rsp_word_t;

  typedef struct packed {
    logic              nonzero;
    logic [BIDX_W-1:0] index;
  } low_bit_t;

  // SWAR bit count of a 32-bit word
  function automatic logic [5:0] popcount32(input logic [31:0] x);
    logic [31:0] v;
    logic [31:0] p;
    v = x - ((x >> 1) & POP_M1);
    v = (v & POP_M2) + ((v >> 2) & POP_M2);
    v = (v + (v >> 4)) & POP_M4;
    p = v * POP_M8;
    return p[29:24];
  endfunction

endpackage

FILE: rtl/bfns_low_index.sv
// Lowest set bit at or above a start bit within one bitmap word.
module bfns_low_index
  import bfns_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  logic [BIDX_W-1:0]    start_bit,
  input  logic                 apply_start,
  output low_bit_t             result
);

  logic [WORD_BITS-1:0] masked;
  logic [WORD_BITS-1:0] lowest;
  logic [5:0]           cnt;

  always_comb begin
    masked = apply_start ? (word & ({WORD_BITS{1'b1}} << start_bit)) : word;
    // isolate lowest one, its index is the count of ones below it
    lowest = masked & (~masked + {{(WORD_BITS-1){1'b0}}, 1'b1});
    cnt    = popcount32(lowest - {{(WORD_BITS-1){1'b0}}, 1'b1});
    result.nonzero = |masked;
    result.index   = cnt[BIDX_W-1:0];
  end

endmodule

FILE: rtl/bitmap_find_next_set.sv
// Top level of the bitmap store with set, clear, test, clear-all and find-next-set.
//
// A 4096-bit map held as 128 words of 32 bits in one synchronous RAM with a
// registered read. A valid flop per word (cleared by reset and by clear-all)
// makes never-written or cleared words read as zero, so there is no clearing
// pass and clear-all finishes at once. Commands are taken one at a time on
// the cmd channel; each gives exactly one word on the rsp channel, held in an
// output register so the next command is accepted while a response waits.
// Per command: out-of-range, clear-all and unused kinds are answered from ST_IMM;
// set, clear and test do a RAM read, then modify/write-back or bit pick.
// Find reads the start word, then scans further words, up to all 128 words
// for a sparse map; the scan moves one word per cycle, bound by the single
// RAM read port, and stops early once the next word lies beyond bits_in_use.
// bits_in_use (APB register at byte 0, reset 4096) bounds search and flags
// positions at or above it as out of range; such commands change nothing.
module bitmap_find_next_set
  import bfns_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // command word
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_word_t          cmd,
  // response word
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_word_t          rsp,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_IMM,
    ST_WORK
  } state_t;

  state_t                state;
  logic [KIND_W-1:0]     kind_q;
  logic [POS_W-1:0]      pos_q;
  logic [WIDX_W-1:0]     cur_w;
  logic                  imm_oor;
  logic [LIMIT_W-1:0]    bits_in_use;
  logic [NUM_WORDS-1:0]  word_valid;

  // bitmap RAM
  logic [WORD_BITS-1:0]  mem [NUM_WORDS];
  logic [WORD_BITS-1:0]  rd_data;
  logic                  rd_valid;
  logic [WIDX_W-1:0]     mem_raddr;
  logic                  mem_we;
  logic [WORD_BITS-1:0]  mem_wdata;

  // datapath
  logic                  cmd_acc;
  logic                  cmd_in_range_kind;
  logic                  cmd_oor;
  logic                  cmd_imm;
  logic                  out_free;
  logic [WORD_BITS-1:0]  cur_word;
  logic [WORD_BITS-1:0]  bit_mask;
  logic                  first_word;
  low_bit_t              low;
  logic [POS_W-1:0]      hit_pos;
  logic                  hit_ok;
  logic [WIDX_W:0]       next_w;
  logic [LIMIT_W-1:0]    next_start;
  logic                  scan_end;
  logic                  advance;
  logic                  rsp_load;
  rsp_word_t             rsp_next;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == ADDR_BITS_IN_USE[PADDR_W-1:2])
                  ? {{(32-LIMIT_W){1'b0}}, bits_in_use} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= LIMIT_RESET;
    end else if (psel && penable && pwrite &&
                 paddr[PADDR_W-1:2] == ADDR_BITS_IN_USE[PADDR_W-1:2]) begin
      bits_in_use <= pwdata[LIMIT_W-1:0];
    end
  end

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    cmd_in_range_kind = (cmd.kind == KIND_SET)  || (cmd.kind == KIND_CLEAR) ||
                        (cmd.kind == KIND_TEST) || (cmd.kind == KIND_FIND);
    // position is 12 bits, so comparing against the raw register
    // already saturates the limit at the map size
    cmd_oor = cmd_in_range_kind && ({1'b0, cmd.position} >= bits_in_use);
    cmd_imm = cmd_oor || !cmd_in_range_kind;
  end

  // current word: a word never written since the last clear reads as zero
  assign cur_word   = rd_valid ? rd_data : '0;
  assign bit_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos_q[BIDX_W-1:0];
  assign first_word = (cur_w == pos_q[POS_W-1:BIDX_W]);

  bfns_low_index u_low (
    .word        (cur_word),
    .start_bit   (pos_q[BIDX_W-1:0]),
    .apply_start (first_word),
    .result      (low)
  );

  always_comb begin
    hit_pos    = {cur_w, low.index};
    hit_ok     = ({1'b0, hit_pos} < bits_in_use);
    next_w     = {1'b0, cur_w} + {{WIDX_W{1'b0}}, 1'b1};
    next_start = {next_w, {BIDX_W{1'b0}}};
    // nothing past this word can be reported
    scan_end   = (cur_w == WIDX_W'(NUM_WORDS - 1)) || (next_start >= bits_in_use);
    advance    = (state == ST_WORK) && (kind_q == KIND_FIND) &&
                 !low.nonzero && !scan_end;
  end

  // response word built in one place, loaded when the output register is free
  always_comb begin
    rsp_load = 1'b0;
    rsp_next = '0;
    case (state)
      ST_IMM: begin
        rsp_load              = out_free;
        rsp_next.out_of_range = imm_oor;
      end
      ST_WORK: begin
        rsp_load = out_free && !advance;
        case (kind_q)
          KIND_TEST: begin
            rsp_next.bit_value = cur_word[pos_q[BIDX_W-1:0]];
          end
          KIND_FIND: begin
            if (low.nonzero && hit_ok) begin
              rsp_next.found          = 1'b1;
              rsp_next.found_position = hit_pos;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state == ST_IDLE) begin
      mem_raddr = cmd.position[POS_W-1:BIDX_W];
    end else if (advance) begin
      mem_raddr = next_w[WIDX_W-1:0];
    end else begin
      mem_raddr = cur_w;
    end
  end

  always_comb begin
    mem_we    = (state == ST_WORK) && out_free &&
                ((kind_q == KIND_SET) || (kind_q == KIND_CLEAR));
    mem_wdata = (kind_q == KIND_SET) ? (cur_word | bit_mask) : (cur_word & ~bit_mask);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_w] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rsp_valid  <= 1'b0;
      word_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= word_valid[mem_raddr];
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_acc) begin
            kind_q  <= cmd.kind;
            pos_q   <= cmd.position;
            cur_w   <= cmd.position[POS_W-1:BIDX_W];
            imm_oor <= cmd_oor;
            if (cmd.kind == KIND_CLEAR_ALL) begin
              word_valid <= '0;
            end
            state <= cmd_imm ? ST_IMM : ST_WORK;
          end
        end
        ST_IMM: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_WORK: begin
          if (advance) begin
            cur_w <= next_w[WIDX_W-1:0];
          end else if (out_free) begin
            if ((kind_q == KIND_SET) || (kind_q == KIND_CLEAR)) begin
              word_valid[cur_w] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
